@@ hw/rtl/sgsh_pkg.sv @@
// Shared types, widths, register codes and reset values for the gear selector.
package sgsh_pkg;

	localparam int SPEED_W       = 16;
	localparam int TIME_W        = 32;
	localparam int GEAR_W        = 5;
	localparam int ANGLE_W       = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int MAX_GEARS_DEF = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPEED  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GEAR_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX   = 3'd5;

	// Register reset values
	localparam logic [SPEED_W-1:0] FIRST_SPEED_RST = 16'd1280;
	localparam logic [SPEED_W-1:0] LAST_SPEED_RST  = 16'd6400;
	localparam logic [GEAR_W-1:0]  GEAR_COUNT_RST  = 5'd8;
	localparam logic [15:0]        COOLDOWN_RST    = 16'd1000;
	localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST   = 8'd0;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST   = 8'd180;

	localparam logic [GEAR_W-1:0] GEAR_ONE  = 5'd1;
	localparam logic [GEAR_W-1:0] GEAR_TWO  = 5'd2;
	localparam logic [GEAR_W-1:0] GEAR_MINC = 5'd3;

	typedef struct packed {
		logic [SPEED_W-1:0] speed_sample;
		logic [TIME_W-1:0]  now_ms;
	} sample_t;

	typedef struct packed {
		logic [GEAR_W-1:0]  current_gear;
		logic [ANGLE_W-1:0] servo_angle;
		logic               shifted;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_TGT_START,
		ST_TGT_WAIT,
		ST_DECIDE,
		ST_ANG_START,
		ST_ANG_WAIT,
		ST_ANG_MUL,
		ST_ANG_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic load_prod;
		logic load_tgt_direct;
		logic div_start;
		logic div_angle;
		logic load_tgt_div;
		logic set_shift;
		logic load_step;
		logic load_aprod;
		logic load_angle;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic cool_ok;
		logic mid_range;
		logic shift_ok;
		logic div_done;
		logic out_free;
	} dp_sts_t;

endpackage

@@ hw/rtl/sgsh_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module sgsh_div #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             fits;

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// remainder stays below the divisor, so DEN_W bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ hw/rtl/sgsh_dp.sv @@
// Datapath: config registers, held gear state, target and angle arithmetic, result register.
module sgsh_dp #(
	parameter int MAX_GEARS = sgsh_pkg::MAX_GEARS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sgsh_pkg::sample_t                       sample,
	input  logic                                    cfg_we,
	input  logic [sgsh_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [sgsh_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  sgsh_pkg::dp_cmd_t                       cmd,
	output sgsh_pkg::dp_sts_t                       sts,
	input  logic                                    result_stall,
	output logic                                    result_valid,
	output sgsh_pkg::result_t                       result
);

	import sgsh_pkg::*;

	localparam int GSEL_W     = $clog2(MAX_GEARS);
	localparam int PROD_W     = SPEED_W + GSEL_W;
	localparam int ANG_PROD_W = GEAR_W + ANGLE_W;
	localparam logic [GEAR_W-1:0] G_MAX = GEAR_W'(MAX_GEARS);

	// Configuration
	logic [SPEED_W-1:0] first_speed_q, last_speed_q;
	logic [GEAR_W-1:0]  gear_count_q;
	logic [15:0]        cooldown_q;
	logic [ANGLE_W-1:0] angle_min_q, angle_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_speed_q <= FIRST_SPEED_RST;
			last_speed_q  <= LAST_SPEED_RST;
			gear_count_q  <= GEAR_COUNT_RST;
			cooldown_q    <= COOLDOWN_RST;
			angle_min_q   <= ANGLE_MIN_RST;
			angle_max_q   <= ANGLE_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_SPEED: first_speed_q <= cfg_data;
				CFG_LAST_SPEED:  last_speed_q  <= cfg_data;
				CFG_GEAR_COUNT:  gear_count_q  <= cfg_data[GEAR_W-1:0];
				CFG_COOLDOWN:    cooldown_q    <= cfg_data;
				CFG_ANGLE_MIN:   angle_min_q   <= cfg_data[ANGLE_W-1:0];
				CFG_ANGLE_MAX:   angle_max_q   <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample and working registers
	logic [SPEED_W-1:0]    speed_q;
	logic [TIME_W-1:0]     now_q;
	logic [PROD_W-1:0]     prod_q;
	logic [GEAR_W-1:0]     tgt_q;
	logic                  shift_q;
	logic [ANGLE_W-1:0]    step_q;
	logic [ANG_PROD_W-1:0] aprod_q;
	logic [ANGLE_W-1:0]    new_angle_q;

	// Held state
	logic [GEAR_W-1:0]  held_gear_q;
	logic               last_down_q;
	logic [TIME_W-1:0]  last_ms_q;
	logic [ANGLE_W-1:0] held_angle_q;

	logic [GEAR_W-1:0]     eff_g, gsub2, direct_tgt, div_tgt, diff;
	logic                  below, above, down, suppress, inverted;
	logic [PROD_W-1:0]     div_num, quo;
	logic [SPEED_W-1:0]    div_den;
	logic                  div_done;
	logic [ANGLE_W-1:0]    angle_span, fin_angle;
	logic [ANG_PROD_W:0]   asum;

	always_comb begin
		if (gear_count_q < GEAR_MINC)
			eff_g = GEAR_MINC;
		else if (gear_count_q > G_MAX)
			eff_g = G_MAX;
		else
			eff_g = gear_count_q;
	end

	assign gsub2 = eff_g - GEAR_TWO;
	assign below = speed_q < first_speed_q;
	assign above = speed_q > last_speed_q;
	assign direct_tgt = below ? GEAR_ONE : (above ? eff_g : GEAR_TWO);

	assign angle_span = angle_max_q - angle_min_q;
	assign inverted   = angle_max_q < angle_min_q;

	assign div_num = cmd.div_angle ? PROD_W'(angle_span) : prod_q;
	assign div_den = cmd.div_angle ? SPEED_W'(eff_g - GEAR_ONE)
	                               : (last_speed_q - first_speed_q);

	sgsh_div #(
		.NUM_W(PROD_W),
		.DEN_W(SPEED_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (quo),
		.done     (div_done)
	);

	assign div_tgt = (quo > PROD_W'(gsub2)) ? eff_g : (GEAR_W'(quo) + GEAR_TWO);

	// Hysteresis: a one-gear step against the last shift direction is held off
	assign down     = tgt_q < held_gear_q;
	assign diff     = down ? (held_gear_q - tgt_q) : (tgt_q - held_gear_q);
	assign suppress = (down != last_down_q) && (diff == GEAR_ONE);

	assign asum = (ANG_PROD_W + 1)'(angle_min_q) + {1'b0, aprod_q};
	always_comb begin
		if (inverted)
			fin_angle = angle_min_q;
		else if (asum > (ANG_PROD_W + 1)'(angle_max_q))
			fin_angle = angle_max_q;
		else
			fin_angle = asum[ANGLE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			speed_q <= sample.speed_sample;
			now_q   <= sample.now_ms;
		end
		if (cmd.load_prod)
			prod_q <= PROD_W'(speed_q - first_speed_q) * PROD_W'(gsub2[GSEL_W-1:0]);
		if (cmd.load_tgt_direct)
			tgt_q <= direct_tgt;
		else if (cmd.load_tgt_div)
			tgt_q <= div_tgt;
		if (cmd.load_step)
			step_q <= quo[ANGLE_W-1:0];
		if (cmd.load_aprod)
			aprod_q <= ANG_PROD_W'(tgt_q - GEAR_ONE) * ANG_PROD_W'(step_q);
		if (cmd.load_angle)
			new_angle_q <= fin_angle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q      <= 1'b0;
			held_gear_q  <= GEAR_ONE;
			last_down_q  <= 1'b0;
			last_ms_q    <= '0;
			held_angle_q <= ANGLE_MIN_RST;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			if (cmd.load_in)
				shift_q <= 1'b0;
			else if (cmd.set_shift)
				shift_q <= 1'b1;
			if (cmd.commit) begin
				result_valid        <= 1'b1;
				result.shifted      <= shift_q;
				result.current_gear <= shift_q ? tgt_q : held_gear_q;
				result.servo_angle  <= shift_q ? new_angle_q : held_angle_q;
				if (shift_q) begin
					held_gear_q  <= tgt_q;
					last_down_q  <= down;
					last_ms_q    <= now_q;
					held_angle_q <= new_angle_q;
				end
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	assign sts.cool_ok   = (now_q - last_ms_q) >= TIME_W'(cooldown_q);
	assign sts.mid_range = !below && !above && (last_speed_q != first_speed_q);
	assign sts.shift_ok  = (tgt_q != held_gear_q) && !suppress;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !result_valid || !result_stall;

endmodule

@@ hw/rtl/sgsh_ctrl.sv @@
// Controller state machine sequencing one sample through the datapath.
module sgsh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sgsh_pkg::dp_sts_t sts,
	output sgsh_pkg::dp_cmd_t cmd
);

	import sgsh_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				cmd.load_prod = 1'b1;
				if (!sts.cool_ok) begin
					state_d = ST_DONE;
				end else if (sts.mid_range) begin
					state_d = ST_TGT_START;
				end else begin
					cmd.load_tgt_direct = 1'b1;
					state_d             = ST_DECIDE;
				end
			end
			ST_TGT_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_TGT_WAIT;
			end
			ST_TGT_WAIT: begin
				if (sts.div_done) begin
					cmd.load_tgt_div = 1'b1;
					state_d          = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.shift_ok) begin
					cmd.set_shift = 1'b1;
					state_d       = ST_ANG_START;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ANG_START: begin
				cmd.div_start = 1'b1;
				cmd.div_angle = 1'b1;
				state_d       = ST_ANG_WAIT;
			end
			ST_ANG_WAIT: begin
				if (sts.div_done) begin
					cmd.load_step = 1'b1;
					state_d       = ST_ANG_MUL;
				end
			end
			ST_ANG_MUL: begin
				cmd.load_aprod = 1'b1;
				state_d        = ST_ANG_FIN;
			end
			ST_ANG_FIN: begin
				cmd.load_angle = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				// wait for the output register to free up
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/speed_gear_selector_hysteresis_unit.sv @@
// Top level of the gear selector: controller, datapath and assertions.
//  - Sample channel (sample_valid / sample_stall / sample): one speed sample in
//    Q8.8 with the current ms time per transfer. Config channel (cfg_valid /
//    cfg_ready / cfg_index / cfg_data) writes one register per transfer; cfg_ready
//    is always high. Write registers only while the block is idle.
//  - Result channel (result_valid / result_stall / result): exactly one result
//    per sample: held gear, servo angle and the shifted flag.
//  - Each division runs on one shared restoring divider. A sample that the
//    cooldown blocks needs no division; outside the speed bounds only a shift
//    divides, for the servo angle; inside the band (distinct bounds) the
//    target gear is divided out, and a shift divides again for the angle.
//  - One sample is in work at a time; sample_stall drops the cycle after its
//    result is loaded into the output register, so the next sample can enter
//    while that result still waits.
//  - When the receiver stalls, the result register holds its value and a
//    finished sample waits in the controller until the register frees up.
//  - Reset: registers take their default values, gear 1, upshift direction,
//    last shift time 0, angle 0; no result is pending.
module speed_gear_selector_hysteresis_unit #(
	parameter int MAX_GEARS = sgsh_pkg::MAX_GEARS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  sgsh_pkg::sample_t               sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output sgsh_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sgsh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sgsh_pkg::CFG_DATA_W-1:0] cfg_data
);

	import sgsh_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	sgsh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	sgsh_dp #(
		.MAX_GEARS(MAX_GEARS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

	// Only one sample in work: after a transfer the input is held off
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("sample accepted while another is in work");

	// A result cannot appear the cycle right after a sample transfer
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> !$rose(result_valid))
		else $error("result appeared too early");

	// Reported gear stays within the supported range
	a_gear_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.current_gear != 0) &&
			(result.current_gear <= GEAR_W'(MAX_GEARS)))
		else $error("gear out of range");

endmodule

@@ sim/gear_shift_checker.sv @@
// Gear selector checker: predicts gear, servo angle and shift flag, compares results.
`timescale 1ns / 1ps
module gear_shift_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	input  logic                            sample_stall,
	input  sgsh_pkg::sample_t               sample,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  sgsh_pkg::result_t               result,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [sgsh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sgsh_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              results_owed
);

	import sgsh_pkg::*;

	// shadow registers
	logic [SPEED_W-1:0] first_speed, last_speed;
	logic [15:0]        cooldown_ms;
	logic [GEAR_W-1:0]  gear_count;
	logic [ANGLE_W-1:0] angle_min, angle_max;

	// shadow state
	logic [GEAR_W-1:0]  held_gear;
	logic [ANGLE_W-1:0] held_angle;
	logic [TIME_W-1:0]  last_shift_ms;
	logic               going_down;

	// working values
	logic [GEAR_W-1:0]  g_eff, tgt, gap;
	logic               down_now, shift_now;
	logic [31:0]        elapsed, spd32, lo32, hi32, g32, quo, step, ang;
	result_t            want;
	result_t            owed_q[$];
	int                 errs = 0;
	int                 owed = 0;

	assign fail_count   = errs;
	assign results_owed = owed;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_speed   = FIRST_SPEED_RST;
			last_speed    = LAST_SPEED_RST;
			gear_count    = GEAR_COUNT_RST;
			cooldown_ms   = COOLDOWN_RST;
			angle_min     = ANGLE_MIN_RST;
			angle_max     = ANGLE_MAX_RST;
			held_gear     = GEAR_ONE;
			held_angle    = ANGLE_MIN_RST;
			last_shift_ms = '0;
			going_down    = 1'b0;
			owed_q.delete();
			owed = 0;
		end else begin
			// result first: it always belongs to an older sample
			if (result_valid && !result_stall) begin
				if (owed_q.size() == 0) begin
					$error("unexpected result transfer: gear %0d angle %0d shifted %0d",
						result.current_gear, result.servo_angle, result.shifted);
					errs++;
				end else begin
					want = owed_q.pop_front();
					if (result.current_gear !== want.current_gear) begin
						$error("current_gear: expected %0d, actual %0d",
							want.current_gear, result.current_gear);
						errs++;
					end
					if (result.servo_angle !== want.servo_angle) begin
						$error("servo_angle: expected %0d, actual %0d",
							want.servo_angle, result.servo_angle);
						errs++;
					end
					if (result.shifted !== want.shifted) begin
						$error("shifted: expected %0d, actual %0d",
							want.shifted, result.shifted);
						errs++;
					end
				end
			end

			if (sample_valid && !sample_stall) begin
				shift_now = 1'b0;
				elapsed   = sample.now_ms - last_shift_ms;
				if (elapsed >= 32'(cooldown_ms)) begin
					g_eff = gear_count;
					if (g_eff < GEAR_MINC)
						g_eff = GEAR_MINC;
					if (g_eff > MAX_GEARS_DEF)
						g_eff = GEAR_W'(MAX_GEARS_DEF);
					g32   = 32'(g_eff);
					spd32 = 32'(sample.speed_sample);
					lo32  = 32'(first_speed);
					hi32  = 32'(last_speed);
					if (spd32 < lo32)
						tgt = GEAR_ONE;
					else if (spd32 > hi32)
						tgt = g_eff;
					else if (hi32 == lo32)
						tgt = GEAR_TWO;
					else begin
						// inside the band, so hi32 > lo32 here
						quo = 32'd2 + (spd32 - lo32) * (g32 - 32'd2) / (hi32 - lo32);
						tgt = (quo > g32) ? g_eff : quo[GEAR_W-1:0];
					end
					if (tgt != held_gear) begin
						down_now = (tgt < held_gear);
						gap      = down_now ? held_gear - tgt : tgt - held_gear;
						// single-gear step against the last direction is held back
						if (!(down_now != going_down && gap == GEAR_ONE)) begin
							held_gear     = tgt;
							last_shift_ms = sample.now_ms;
							going_down    = down_now;
							shift_now     = 1'b1;
							if (angle_max < angle_min)
								held_angle = angle_min;
							else begin
								step = (32'(angle_max) - 32'(angle_min)) / (g32 - 32'd1);
								ang  = 32'(angle_min) + (32'(tgt) - 32'd1) * step;
								if (ang < 32'(angle_min))
									ang = 32'(angle_min);
								if (ang > 32'(angle_max))
									ang = 32'(angle_max);
								held_angle = ang[ANGLE_W-1:0];
							end
						end
					end
				end
				owed_q.push_back({held_gear, held_angle, shift_now});
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIRST_SPEED: first_speed = cfg_data;
					CFG_LAST_SPEED:  last_speed  = cfg_data;
					CFG_GEAR_COUNT:  gear_count  = cfg_data[GEAR_W-1:0];
					CFG_COOLDOWN:    cooldown_ms = cfg_data;
					CFG_ANGLE_MIN:   angle_min   = cfg_data[ANGLE_W-1:0];
					CFG_ANGLE_MAX:   angle_max   = cfg_data[ANGLE_W-1:0];
					default: ;
				endcase
			end

			owed = owed_q.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
// Testbench top: clock, reset, sample and config stimulus, result stalls, verdict.
`timescale 1ns / 1ps
module testbench;
	import sgsh_pkg::*;

	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 64;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int STEADY_PHASE    = 4;
	localparam int HOLD_PHASE      = 1;
	localparam int PAUSE_PHASE     = 6;
	localparam int WRAP_PHASE      = 7;
	// decoded by nothing, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	sample_t               sample;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    results_owed;

	bit steady  = 1'b0;
	bit hold_req = 1'b0;
	int idle_cycles = 0;
	int cur_first, cur_last, cur_cool;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	speed_gear_selector_hysteresis_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	gear_shift_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	// no transfer of any kind for too long means the block is stuck
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	// result side: random stalls (none in the steady phase), one long hold-off on request
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					result_stall <= 1'b1;
				end
			end else if (steady)
				result_stall <= 1'b0;
			else
				result_stall <= ($urandom_range(99) < 34);
		end
	end

	task automatic send_sample(input logic [SPEED_W-1:0] spd, input logic [TIME_W-1:0] ms);
		if (!steady) begin
			while ($urandom_range(99) < 34) begin
				@(negedge clk);
				sample_valid <= 1'b0;
			end
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample       <= {spd, ms};
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	// stop offering and wait until every owed result has been taken
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_config(input logic [15:0] first, input logic [15:0] last,
			input logic [15:0] gears, input logic [15:0] cool,
			input logic [15:0] amin, input logic [15:0] amax);
		write_reg(CFG_FIRST_SPEED, first);
		write_reg(CFG_LAST_SPEED, last);
		write_reg(CFG_GEAR_COUNT, gears);
		write_reg(CFG_COOLDOWN, cool);
		write_reg(CFG_ANGLE_MIN, amin);
		write_reg(CFG_ANGLE_MAX, amax);
		cur_first = int'(first);
		cur_last  = int'(last);
		cur_cool  = int'(cool);
	endtask

	initial begin
		int ph, n, lo, hi, span, w, spd, roll, amin;
		logic [TIME_W-1:0] t_now;

		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		cur_first    = int'(FIRST_SPEED_RST);
		cur_last     = int'(LAST_SPEED_RST);
		cur_cool     = int'(COOLDOWN_RST);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: cooldown from time zero, hysteresis in both directions
		send_sample(16'd0, 32'd0);
		send_sample(16'hFFFF, 32'd999);
		send_sample(16'hFFFF, 32'd1000);
		send_sample(16'd0, 32'd1999);
		send_sample(16'd0, 32'd2000);
		send_sample(16'd1280, 32'd3000);
		send_sample(16'd1279, 32'd4000);
		send_sample(16'd6400, 32'd5000);
		send_sample(16'd5547, 32'd6000);
		send_sample(16'd4694, 32'd7000);
		send_sample(16'd5547, 32'd8000);
		send_sample(16'd3840, 32'd9000);
		// elapsed time across the 32-bit wrap
		send_sample(16'hFFFF, 32'hFFFF_FF00);
		send_sample(16'd0, 32'h0000_0100);
		send_sample(16'd1000, 32'hFFFF_FFFF);
		send_sample(16'd0, 32'h0000_0400);
		drain();

		// equal speed bounds, gear count above the maximum, no cooldown
		load_config(16'd3000, 16'd3000, 16'd31, 16'd0, 16'd10, 16'd200);
		send_sample(16'hFFFF, 32'h0001_0000);
		send_sample(16'd3000, 32'h0001_0001);
		send_sample(16'd3001, 32'h0001_0002);
		drain();

		// inverted speed and angle bounds, gear count below the minimum
		load_config(16'd5000, 16'd1000, 16'd0, 16'd0, 16'd150, 16'd20);
		send_sample(16'd3000, 32'h0001_0003);
		send_sample(16'hFFFF, 32'h0001_0004);
		send_sample(16'd0, 32'h0001_0005);
		send_sample(16'd5000, 32'h0001_0006);
		drain();

		// full-range bounds, longest cooldown
		load_config(16'd0, 16'hFFFF, 16'd16, 16'hFFFF, 16'd0, 16'd255);
		write_reg(CFG_SPARE6, 16'hFFFF);
		write_reg(CFG_SPARE7, 16'h5A5A);
		send_sample(16'hFFFF, 32'h0002_0004);
		send_sample(16'hFFFF, 32'h0002_0005);
		send_sample(16'd0, 32'h0003_0004);

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			steady = (ph == STEADY_PHASE);
			if (ph % 3 == 2)
				load_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			else begin
				lo   = $urandom_range(0, 20000);
				amin = $urandom_range(0, 90);
				load_config(16'(lo), 16'(lo + $urandom_range(1, 30000)),
					16'($urandom_range(3, 16)), 16'($urandom_range(0, 300)),
					16'(amin), 16'($urandom_range(amin, 180)));
			end
			lo    = (cur_first < cur_last) ? cur_first : cur_last;
			hi    = (cur_first < cur_last) ? cur_last : cur_first;
			span  = hi - lo + 1;
			w     = span / 8 + 1;
			spd   = lo;
			t_now = (ph == WRAP_PHASE) ? 32'hFFFF_FFFF - 32'd3000 : $urandom();
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2) begin
					if (ph == HOLD_PHASE)
						hold_req = 1'b1;
					if (ph == PAUSE_PHASE)
						drain();
				end
				roll = $urandom_range(99);
				if (roll < 8)
					spd = $urandom_range(0, 65535);
				else if (roll < 25)
					spd = lo - span / 4 + int'($urandom_range(0, span + span / 2));
				else
					spd = spd + int'($urandom_range(0, 2 * w)) - w;
				if (spd < 0)
					spd = 0;
				if (spd > 65535)
					spd = 65535;
				roll = $urandom_range(99);
				if (roll < 5)
					t_now = $urandom();
				else if (roll > 8)
					t_now = t_now + $urandom_range(0, 2 * cur_cool + 4);
				send_sample(spd[SPEED_W-1:0], t_now);
			end
		end
		steady = 1'b0;
		drain();

		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/sgsh_pkg.sv
hw/rtl/sgsh_div.sv
hw/rtl/sgsh_dp.sv
hw/rtl/sgsh_ctrl.sv
hw/rtl/speed_gear_selector_hysteresis_unit.sv
sim/gear_shift_checker.sv
sim/testbench.sv
